[rtl/udrb_pkg.sv]
// udrb_pkg: shared types, codes and defaults for the uart dual ring buffer
// depends on nothing; imported by every rtl file of the block
package udrb_pkg;

    localparam int DEF_PORTS        = 2;
    localparam int DEF_BUFFER_DEPTH = 64;

    localparam int BYTE_W      = 8;
    localparam int CMD_W       = 3;
    localparam int PORT_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int TX_LEVEL_W  = 7;
    localparam int RX_LEVEL_W  = 8;
    localparam logic [RX_LEVEL_W-1:0] RX_CNT_MAX = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT_TX   = 3'd0,
        CMD_TX_READY = 3'd1,
        CMD_RX_BYTE  = 3'd2,
        CMD_GET      = 3'd3,
        CMD_PEEK     = 3'd4,
        CMD_FLUSH_TX = 3'd5,
        CMD_FLUSH_RX = 3'd6,
        CMD_CHECK    = 3'd7
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_BAD_PORT = 2'd1,
        STAT_TX_FULL  = 2'd2,
        STAT_EMPTY    = 2'd3
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RESP = 1'b1
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [PORT_W-1:0] port;
        logic [BYTE_W-1:0] byte_in;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0]     byte_out;
        logic                  byte_valid;
        logic [STATUS_W-1:0]   status;
        logic [TX_LEVEL_W-1:0] tx_level;
        logic [RX_LEVEL_W-1:0] rx_level;
        logic                  overflow_seen;
    } t_out_item;

endpackage

[rtl/uart_dual_ring_buffer_unit.sv]
// uart dual ring buffer: per-port transmit and receive byte rings
// latency: a transaction taken at one edge shows its result, with o_done, in the next cycle
// no new transaction is taken while busy; busy is high while the result is shown with o_done
// reset: synchronous, active low; clears all indexes, counts and the sequencer, not the rams
// the receiver cannot stall: each result is shown for exactly one cycle
// depends on udrb_pkg and udrb_ram
module uart_dual_ring_buffer_unit
    import udrb_pkg::*;
#(
    parameter int PORTS        = DEF_PORTS,
    parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_done,
    output t_out_item o_result
);

    // widths derived from the geometry
    localparam int PW     = (PORTS > 1) ? $clog2(PORTS) : 1;
    localparam int IDX_W  = $clog2(BUFFER_DEPTH);
    localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);
    localparam int MEM_D  = PORTS * BUFFER_DEPTH;
    localparam int ADDR_W = $clog2(MEM_D);

    localparam logic [IDX_W-1:0]      IDX_LAST   = IDX_W'(BUFFER_DEPTH - 1);
    localparam logic [CNT_W-1:0]      TX_FULL    = CNT_W'(BUFFER_DEPTH);
    localparam logic [RX_LEVEL_W-1:0] RX_FULL    = RX_LEVEL_W'(BUFFER_DEPTH);
    localparam logic [ADDR_W-1:0]     RING_SPAN  = ADDR_W'(BUFFER_DEPTH);

    // per-port ring indexes and counts
    logic [IDX_W-1:0]      r_tx_head [PORTS];
    logic [IDX_W-1:0]      r_tx_tail [PORTS];
    logic [CNT_W-1:0]      r_tx_cnt  [PORTS];
    logic [IDX_W-1:0]      r_rx_head [PORTS];
    logic [IDX_W-1:0]      r_rx_tail [PORTS];
    logic [RX_LEVEL_W-1:0] r_rx_cnt  [PORTS];
    logic [IDX_W-1:0]      n_tx_head [PORTS];
    logic [IDX_W-1:0]      n_tx_tail [PORTS];
    logic [CNT_W-1:0]      n_tx_cnt  [PORTS];
    logic [IDX_W-1:0]      n_rx_head [PORTS];
    logic [IDX_W-1:0]      n_rx_tail [PORTS];
    logic [RX_LEVEL_W-1:0] n_rx_cnt  [PORTS];

    // sequencer and held response
    t_state    r_state, n_state;
    t_out_item r_res, n_res;
    logic      r_src_tx, n_src_tx;

    // ram access for the transaction being taken
    logic              take;
    logic              port_ok;
    logic [PW-1:0]     p;
    logic              tx_we, rx_we;
    logic [IDX_W-1:0]  tx_idx, rx_idx;
    logic [ADDR_W-1:0] tx_addr, rx_addr;
    logic [BYTE_W-1:0] tx_rdata, rx_rdata;

    function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] i);
        wrap_next = (i == IDX_LAST) ? '0 : i + 1'b1;
    endfunction

    assign take    = start && !busy;
    assign port_ok = (i_item.port < PORT_W'(PORTS)) || (PORTS >= (1 << PORT_W));
    assign p       = port_ok ? i_item.port[PW-1:0] : '0;

    // ring slot of port p sits at p * depth + index
    assign tx_addr = ADDR_W'(p) * RING_SPAN + ADDR_W'(tx_idx);
    assign rx_addr = ADDR_W'(p) * RING_SPAN + ADDR_W'(rx_idx);

    // command decode: index and count updates, ram strobes, response fields
    always_comb begin
        n_tx_head = r_tx_head;
        n_tx_tail = r_tx_tail;
        n_tx_cnt  = r_tx_cnt;
        n_rx_head = r_rx_head;
        n_rx_tail = r_rx_tail;
        n_rx_cnt  = r_rx_cnt;
        n_res     = r_res;
        n_src_tx  = r_src_tx;
        tx_we     = 1'b0;
        rx_we     = 1'b0;
        tx_idx    = r_tx_tail[p];
        rx_idx    = r_rx_tail[p];

        if (take) begin
            n_res          = '0;
            n_src_tx       = 1'b0;
            n_res.status   = port_ok ? STAT_OK : STAT_BAD_PORT;

            if (t_cmd'(i_item.cmd) == CMD_CHECK) begin
                // scans every port whatever the port field says
                for (int q = 0; q < PORTS; q++) begin
                    if (r_rx_cnt[q] >= RX_FULL) begin
                        n_rx_head[q] = '0;
                        n_rx_tail[q] = '0;
                        n_rx_cnt[q]  = '0;
                        n_res.overflow_seen = 1'b1;
                    end
                end
            end else if (port_ok) begin
                case (t_cmd'(i_item.cmd))
                    CMD_PUT_TX: begin
                        if (r_tx_cnt[p] >= TX_FULL) begin
                            n_tx_head[p] = '0;
                            n_tx_tail[p] = '0;
                            n_tx_cnt[p]  = '0;
                            n_res.status = STAT_TX_FULL;
                        end else begin
                            tx_idx       = r_tx_head[p];
                            tx_we        = 1'b1;
                            n_tx_head[p] = wrap_next(r_tx_head[p]);
                            n_tx_cnt[p]  = r_tx_cnt[p] + 1'b1;
                        end
                    end
                    CMD_TX_READY: begin
                        if (r_tx_cnt[p] != '0) begin
                            n_res.byte_valid = 1'b1;
                            n_src_tx         = 1'b1;
                            n_tx_tail[p]     = wrap_next(r_tx_tail[p]);
                            n_tx_cnt[p]      = r_tx_cnt[p] - 1'b1;
                        end else begin
                            n_res.status = STAT_EMPTY;
                        end
                    end
                    CMD_RX_BYTE: begin
                        // no full check: old unread bytes get overwritten
                        rx_idx       = r_rx_head[p];
                        rx_we        = 1'b1;
                        n_rx_head[p] = wrap_next(r_rx_head[p]);
                        if (r_rx_cnt[p] != RX_CNT_MAX) begin
                            n_rx_cnt[p] = r_rx_cnt[p] + 1'b1;
                        end
                    end
                    CMD_GET, CMD_PEEK: begin
                        if (r_rx_cnt[p] != '0) begin
                            n_res.byte_valid = 1'b1;
                            if (t_cmd'(i_item.cmd) == CMD_GET) begin
                                n_rx_tail[p] = wrap_next(r_rx_tail[p]);
                                n_rx_cnt[p]  = r_rx_cnt[p] - 1'b1;
                            end
                        end else begin
                            n_res.status = STAT_EMPTY;
                        end
                    end
                    CMD_FLUSH_TX: begin
                        n_tx_head[p] = '0;
                        n_tx_tail[p] = '0;
                        n_tx_cnt[p]  = '0;
                    end
                    CMD_FLUSH_RX: begin
                        n_rx_head[p] = '0;
                        n_rx_tail[p] = '0;
                        n_rx_cnt[p]  = '0;
                    end
                    default: begin
                    end
                endcase
            end

            // levels after the step, zero for a bad port
            if (port_ok) begin
                n_res.tx_level = TX_LEVEL_W'(n_tx_cnt[p]);
                n_res.rx_level = n_rx_cnt[p];
            end
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        busy   = 1'b0;
        o_done = 1'b0;
        case (r_state)
            ST_IDLE: begin
                busy   = 1'b0;
                o_done = 1'b0;
            end
            ST_RESP: begin
                busy   = 1'b1;
                o_done = 1'b1;
            end
            default: begin
                busy   = 1'b0;
                o_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            for (int q = 0; q < PORTS; q++) begin
                r_tx_head[q] <= '0;
                r_tx_tail[q] <= '0;
                r_tx_cnt[q]  <= '0;
                r_rx_head[q] <= '0;
                r_rx_tail[q] <= '0;
                r_rx_cnt[q]  <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_tx_head <= n_tx_head;
            r_tx_tail <= n_tx_tail;
            r_tx_cnt  <= n_tx_cnt;
            r_rx_head <= n_rx_head;
            r_rx_tail <= n_rx_tail;
            r_rx_cnt  <= n_rx_cnt;
        end
    end

    // response payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_res    <= n_res;
        r_src_tx <= n_src_tx;
    end

    // ring storage, one ram per direction
    udrb_ram #(
        .DEPTH (MEM_D)
    ) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_addr  (tx_addr),
        .i_wdata (i_item.byte_in),
        .o_rdata (tx_rdata)
    );

    udrb_ram #(
        .DEPTH (MEM_D)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_addr  (rx_addr),
        .i_wdata (i_item.byte_in),
        .o_rdata (rx_rdata)
    );

    // byte comes straight from the ram read register; zero when none
    always_comb begin
        o_result = r_res;
        if (r_res.byte_valid) begin
            o_result.byte_out = r_src_tx ? tx_rdata : rx_rdata;
        end else begin
            o_result.byte_out = '0;
        end
    end

endmodule

[rtl/udrb_ram.sv]
// udrb_ram: single-port byte memory with registered read data
// depends on udrb_pkg for the byte width and the default depth
module udrb_ram
    import udrb_pkg::*;
#(
    parameter int DEPTH = DEF_PORTS * DEF_BUFFER_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [BYTE_W-1:0]        i_wdata,
    output logic [BYTE_W-1:0]        o_rdata
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        r_rdata <= mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/udrb_checker.sv]
// udrb_checker: port-level assertions for the uart dual ring buffer
// depends on udrb_pkg; bound to uart_dual_ring_buffer_unit below
module udrb_checker
    import udrb_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input logic      o_done,
    input t_out_item o_result
);

    // every accepted transaction answers in the next cycle
    a_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> o_done)
        else $error("accepted transaction gave no result");

    // no result without a transaction the cycle before
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy))
        else $error("result without transaction");

    // a real byte only comes with ok status
    a_valid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.byte_valid |-> o_result.status == STAT_OK)
        else $error("byte_valid with error status");

    // no byte means a zero byte
    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_result.byte_valid |-> o_result.byte_out == '0)
        else $error("byte_out nonzero without byte_valid");

    // bad port reports empty levels
    a_bad_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.status == STAT_BAD_PORT
            |-> o_result.tx_level == '0 && o_result.rx_level == '0)
        else $error("levels nonzero on bad port");

endmodule

bind uart_dual_ring_buffer_unit udrb_checker u_udrb_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

[sim/tb.sv]
// tb: self-checking testbench for uart_dual_ring_buffer_unit, per-port tx and rx byte rings
// a scoreboard class predicts every response, plain tasks drive commands through start/busy
// depends on udrb_pkg and the rtl of the block
module tb
    import udrb_pkg::*;
();

    localparam int PORTS = DEF_PORTS;
    localparam int DEPTH = DEF_BUFFER_DEPTH;
    localparam int MAX_SHOWN = 10;

    class ring_scoreboard;
        logic [BYTE_W-1:0]     tx_mem [PORTS][DEPTH];
        logic [BYTE_W-1:0]     rx_mem [PORTS][DEPTH];
        int unsigned           tx_wr [PORTS];
        int unsigned           tx_rd [PORTS];
        int unsigned           rx_wr [PORTS];
        int unsigned           rx_rd [PORTS];
        logic [TX_LEVEL_W-1:0] tx_cnt [PORTS];
        logic [RX_LEVEL_W-1:0] rx_cnt [PORTS];
        t_out_item             due_responses [$];
        int mismatches, n_responses, n_full, n_empty, n_bad_port, n_overflow, peak_rx;

        function new();
            for (int p = 0; p < PORTS; p++) begin
                tx_wr[p] = 0; tx_rd[p] = 0; tx_cnt[p] = '0;
                rx_wr[p] = 0; rx_rd[p] = 0; rx_cnt[p] = '0;
                for (int i = 0; i < DEPTH; i++) begin
                    tx_mem[p][i] = '0;
                    rx_mem[p][i] = '0;
                end
            end
            mismatches = 0; n_responses = 0; n_full = 0; n_empty = 0;
            n_bad_port = 0; n_overflow = 0; peak_rx = 0;
        endfunction

        function int unsigned next_slot(int unsigned i);
            return (i + 1 >= DEPTH) ? 0 : i + 1;
        endfunction

        // work out the response of one accepted command and queue it
        function void note_command(t_in_item it);
            t_out_item   want;
            t_cmd        c;
            int unsigned p;
            bit          ok;
            want = '0;
            c    = t_cmd'(it.cmd);
            p    = it.port;
            ok   = (p < PORTS);
            if (c == CMD_CHECK) begin
                // scans every port whatever the port field says
                for (int q = 0; q < PORTS; q++) begin
                    if (rx_cnt[q] >= DEPTH) begin
                        rx_wr[q] = 0; rx_rd[q] = 0; rx_cnt[q] = '0;
                        want.overflow_seen = 1'b1;
                    end
                end
                if (!ok) want.status = STAT_BAD_PORT;
            end else if (!ok) begin
                want.status = STAT_BAD_PORT;
            end else begin
                case (c)
                    CMD_PUT_TX: begin
                        if (tx_cnt[p] >= DEPTH) begin
                            // full ring is dropped along with the byte
                            tx_wr[p] = 0; tx_rd[p] = 0; tx_cnt[p] = '0;
                            want.status = STAT_TX_FULL;
                        end else begin
                            tx_mem[p][tx_wr[p]] = it.byte_in;
                            tx_wr[p] = next_slot(tx_wr[p]);
                            tx_cnt[p] = tx_cnt[p] + 1'b1;
                        end
                    end
                    CMD_TX_READY: begin
                        if (tx_cnt[p] != 0) begin
                            want.byte_out   = tx_mem[p][tx_rd[p]];
                            want.byte_valid = 1'b1;
                            tx_rd[p] = next_slot(tx_rd[p]);
                            tx_cnt[p] = tx_cnt[p] - 1'b1;
                        end else begin
                            want.status = STAT_EMPTY;
                        end
                    end
                    CMD_RX_BYTE: begin
                        // no full check: overwrites unread data, count saturates
                        rx_mem[p][rx_wr[p]] = it.byte_in;
                        rx_wr[p] = next_slot(rx_wr[p]);
                        if (rx_cnt[p] != RX_CNT_MAX) rx_cnt[p] = rx_cnt[p] + 1'b1;
                    end
                    CMD_GET, CMD_PEEK: begin
                        if (rx_cnt[p] != 0) begin
                            want.byte_out   = rx_mem[p][rx_rd[p]];
                            want.byte_valid = 1'b1;
                            if (c == CMD_GET) begin
                                rx_rd[p] = next_slot(rx_rd[p]);
                                rx_cnt[p] = rx_cnt[p] - 1'b1;
                            end
                        end else begin
                            want.status = STAT_EMPTY;
                        end
                    end
                    CMD_FLUSH_TX: begin
                        tx_wr[p] = 0; tx_rd[p] = 0; tx_cnt[p] = '0;
                    end
                    default: begin
                        rx_wr[p] = 0; rx_rd[p] = 0; rx_cnt[p] = '0;
                    end
                endcase
            end
            if (ok) begin
                want.tx_level = tx_cnt[p];
                want.rx_level = rx_cnt[p];
            end
            due_responses.push_back(want);
        endfunction

        function void compare_field(string name, int unsigned want_v, int unsigned got_v);
            if (want_v != got_v) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("tb: response %0d, %s expected %0d, got %0d",
                             n_responses, name, want_v, got_v);
            end
        endfunction

        function void check_response(t_out_item got);
            t_out_item want;
            if (due_responses.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("tb: response with no command waiting: %h", got);
                return;
            end
            want = due_responses.pop_front();
            compare_field("byte_out", want.byte_out, got.byte_out);
            compare_field("byte_valid", want.byte_valid, got.byte_valid);
            compare_field("status", want.status, got.status);
            compare_field("tx_level", want.tx_level, got.tx_level);
            compare_field("rx_level", want.rx_level, got.rx_level);
            compare_field("overflow_seen", want.overflow_seen, got.overflow_seen);
            n_responses++;
            if (want.status == STAT_TX_FULL) n_full++;
            if (want.status == STAT_EMPTY) n_empty++;
            if (want.status == STAT_BAD_PORT) n_bad_port++;
            if (want.overflow_seen) n_overflow++;
            if (want.rx_level > peak_rx) peak_rx = want.rx_level;
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_in_item  cmd_item = '0;
    logic      done;
    t_out_item resp_item;

    ring_scoreboard sb;
    int idle_pct = 0;
    int n_sent = 0;

    uart_dual_ring_buffer_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (cmd_item),
        .o_done   (done),
        .o_result (resp_item)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // responses are checked before the command taken at the same edge is noted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (done) sb.check_response(resp_item);
            if (start && !busy) sb.note_command(cmd_item);
        end
    end

    task automatic send_cmd(input t_cmd c, input int unsigned pt,
                            input int unsigned bv);
        t_in_item it;
        int gap;
        it.cmd     = c;
        it.port    = PORT_W'(pt);
        it.byte_in = BYTE_W'(bv);
        gap = 0;
        if ($urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 4);
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start    <= 1'b1;
        cmd_item <= it;
        do @(posedge i_clk); while (busy);
        n_sent++;
    endtask

    function automatic int unsigned any_good_port();
        return $urandom_range(0, PORTS - 1);
    endfunction

    function automatic int unsigned any_byte();
        return $urandom_range(0, 255);
    endfunction

    task automatic rx_burst(input int unsigned pt, input int n);
        repeat (n) send_cmd(CMD_RX_BYTE, pt, any_byte());
    endtask

    task automatic random_burst();
        int unsigned pt;
        int n, m;
        pt = any_good_port();
        case ($urandom_range(0, 9))
            0, 1: begin
                // queue bytes for transmit, sometimes past full, then drain
                n = $urandom_range(1, 68);
                repeat (n) send_cmd(CMD_PUT_TX, pt, any_byte());
                m = $urandom_range(0, n + 1);
                repeat (m) send_cmd(CMD_TX_READY, pt, any_byte());
            end
            2, 3: begin
                n = $urandom_range(1, 70);
                rx_burst(pt, n);
                m = $urandom_range(0, n + 1);
                repeat (m) begin
                    if ($urandom_range(0, 9) < 7) send_cmd(CMD_GET, pt, any_byte());
                    else send_cmd(CMD_PEEK, pt, any_byte());
                end
            end
            4: begin
                // receive around the depth boundary, then check and peek
                rx_burst(pt, DEPTH - 1 + $urandom_range(0, 2));
                send_cmd(CMD_CHECK, $urandom_range(0, 3), any_byte());
                send_cmd(CMD_PEEK, pt, any_byte());
            end
            5, 6: begin
                n = $urandom_range(4, 16);
                repeat (n) begin
                    if ($urandom_range(0, 9) == 0) pt = $urandom_range(PORTS, 3);
                    else pt = any_good_port();
                    send_cmd(t_cmd'($urandom_range(0, 7)), pt, any_byte());
                end
            end
            7: begin
                n = $urandom_range(1, 6);
                repeat (n)
                    send_cmd(t_cmd'($urandom_range(0, 7)), $urandom_range(0, 3), any_byte());
            end
            default: begin
                if ($urandom_range(0, 1)) send_cmd(CMD_FLUSH_TX, pt, any_byte());
                else send_cmd(CMD_FLUSH_RX, pt, any_byte());
                send_cmd(CMD_CHECK, any_good_port(), any_byte());
                send_cmd(CMD_PUT_TX, pt, any_byte());
                send_cmd(CMD_RX_BYTE, pt, any_byte());
            end
        endcase
    endtask

    initial begin
        int rates [3];
        int quota [3];
        int target;
        int waited;
        sb = new();
        rates = '{0, 71, 23};
        // the last phase carries the rx saturation run, so it gets more commands
        quota = '{130, 130, 300};

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty reads, byte extremes, invalid ports, flushes, check
        send_cmd(CMD_PEEK, 0, 8'h00);
        send_cmd(CMD_GET, 0, 8'hFF);
        send_cmd(CMD_TX_READY, 0, 8'h00);
        send_cmd(CMD_PUT_TX, 0, 8'h00);
        send_cmd(CMD_PUT_TX, 0, 8'hFF);
        send_cmd(CMD_TX_READY, 0, 8'h00);
        send_cmd(CMD_TX_READY, 0, 8'h00);
        send_cmd(CMD_RX_BYTE, 1, 8'hA5);
        send_cmd(CMD_RX_BYTE, 1, 8'h5A);
        send_cmd(CMD_PEEK, 1, 8'h00);
        send_cmd(CMD_GET, 1, 8'h00);
        send_cmd(CMD_GET, 1, 8'h00);
        send_cmd(CMD_GET, 1, 8'h00);
        send_cmd(CMD_PUT_TX, 1, 8'h3C);
        send_cmd(CMD_RX_BYTE, 0, 8'hC3);
        send_cmd(CMD_FLUSH_TX, 1, 8'h00);
        send_cmd(CMD_FLUSH_RX, 0, 8'h00);
        send_cmd(CMD_PUT_TX, 2, 8'h80);
        send_cmd(CMD_GET, 3, 8'h7F);
        send_cmd(CMD_CHECK, 3, 8'h00);
        send_cmd(CMD_CHECK, 0, 8'h00);
        send_cmd(CMD_RX_BYTE, 1, 8'h01);
        send_cmd(CMD_PEEK, 2, 8'h00);
        send_cmd(CMD_TX_READY, 3, 8'hFF);
        send_cmd(CMD_FLUSH_RX, 2, 8'h00);

        // random phases: no idling, heavy sender idling, light sender idling
        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = rates[ph];
            target = n_sent + quota[ph];
            if (ph == 0) begin
                // overfill one tx ring so the put is rejected and the ring flushed
                send_cmd(CMD_FLUSH_TX, 0, 8'h00);
                repeat (DEPTH + 2) send_cmd(CMD_PUT_TX, 0, any_byte());
            end
            if (ph == 2) begin
                // drive the rx count into saturation, read some, then check
                rx_burst(any_good_port(), $urandom_range(256, 270));
                repeat (8) send_cmd(CMD_GET, $urandom_range(0, PORTS - 1), any_byte());
                send_cmd(CMD_CHECK, any_good_port(), any_byte());
            end
            while (n_sent < target) random_burst();
        end

        @(negedge i_clk);
        start <= 1'b0;

        waited = 0;
        while (sb.due_responses.size() != 0 && waited < 1000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);

        $display("tb: %0d commands, %0d responses; %0d rejected puts, %0d empty reads",
                 n_sent, sb.n_responses, sb.n_full, sb.n_empty);
        $display("tb: %0d bad-port commands, %0d overflow flushes, peak rx level %0d",
                 sb.n_bad_port, sb.n_overflow, sb.peak_rx);
        if (sb.due_responses.size() != 0)
            $display("tb: %0d responses never arrived", sb.due_responses.size());
        if (sb.mismatches == 0 && sb.due_responses.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: %0d mismatches", sb.mismatches);
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("tb: run timed out");
        $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
rtl/udrb_pkg.sv
rtl/udrb_ram.sv
rtl/uart_dual_ring_buffer_unit.sv
rtl/udrb_checker.sv
sim/tb.sv
